FILE: rtl/csq_pkg.sv
// Shared types and constants of the counting semaphore wait queue unit.
package csq_pkg;

   localparam int NUM_SEMS_DEF   = 16;
   localparam int NUM_TASKS_DEF  = 16;
   localparam int COUNT_BITS_DEF = 16;
   localparam int PRI_BITS_DEF   = 8;

   // Width of the fixed task number field of the interface.
   localparam int TASK_FIELD_W = 5;

   typedef enum logic [2:0] {
      CMD_CREATE     = 3'd0,
      CMD_CREATE_ANY = 3'd1,
      CMD_DELETE     = 3'd2,
      CMD_SIGNAL     = 3'd3,
      CMD_POLL       = 3'd4,
      CMD_WAIT       = 3'd5,
      CMD_REFER      = 3'd6,
      CMD_DROP       = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_ID      = 3'd1,
      ST_EXISTS      = 3'd2,
      ST_NOT_EXISTS  = 3'd3,
      ST_OVERFLOW    = 3'd4,
      ST_WOULD_BLOCK = 3'd5,
      ST_NO_FREE_ID  = 3'd6,
      ST_QUEUED      = 3'd7
   } status_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_EXEC
   } fsm_type;

   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2
   } cell_op_type;

endpackage

FILE: rtl/csq_cell.sv
// One task cell: the semaphore a task waits on, its queue position and priority.
module csq_cell #(
   parameter int IDX      = 0,
   parameter int SW       = 5,
   parameter int TW       = 5,
   parameter int PRI_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  csq_pkg::cell_op_type         op,
   input  logic [csq_pkg::TASK_FIELD_W-1:0] op_task,
   input  logic [SW-1:0]                op_sem,
   input  logic [TW-1:0]                op_pos,
   input  logic [PRI_BITS-1:0]          op_pri,
   output logic [SW-1:0]                sem,
   output logic [TW-1:0]                pos,
   output logic [PRI_BITS-1:0]          pri
);
   import csq_pkg::*;

   logic [SW-1:0]       sem_ff, sem_in;
   logic [TW-1:0]       pos_ff, pos_in;
   logic [PRI_BITS-1:0] pri_ff, pri_in;
   logic                self_hit;
   logic                same_sem;

   assign self_hit = (32'(op_task) == 32'(IDX + 1));
   assign same_sem = (sem_ff == op_sem) && (sem_ff != '0);

   always_comb begin
      sem_in = sem_ff;
      pos_in = pos_ff;
      pri_in = pri_ff;
      case (op)
         OP_INSERT: begin
            if (self_hit) begin
               sem_in = op_sem;
               pos_in = op_pos;
               pri_in = op_pri;
            end else if (same_sem && pos_ff >= op_pos) begin
               pos_in = pos_ff + TW'(1);
            end
         end
         OP_REMOVE: begin
            if (self_hit) begin
               sem_in = '0;
            end else if (same_sem && pos_ff > op_pos) begin
               pos_in = pos_ff - TW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sem_ff <= '0;
      end else begin
         sem_ff <= sem_in;
      end
      pos_ff <= pos_in;
      pri_ff <= pri_in;
   end

   assign sem = sem_ff;
   assign pos = pos_ff;
   assign pri = pri_ff;

endmodule

FILE: rtl/counting_semaphore_wait_queue_unit.sv
// Top level of the counting semaphore table with ordered wait queues.
//
// The unit keeps NUM_SEMS counting semaphores and a row of NUM_TASKS task
// cells. Each cell records which semaphore its task waits on and the task's
// place in that queue, so a queue is the set of cells sharing a semaphore
// number, ranked by position. A request is taken into the request register
// and executed when its result is written to the output register; no new
// request is taken until then. A delete releases one head waiter per cycle
// while its results are taken, until the queue is empty. A stalled result
// holds the unit until it is taken. Priority queues place a new waiter after
// every waiter of equal or lower value, so equal priorities keep arrival
// order. All semaphores are inactive and no task waits after reset.
module counting_semaphore_wait_queue_unit #(
   parameter int NUM_SEMS   = csq_pkg::NUM_SEMS_DEF,
   parameter int NUM_TASKS  = csq_pkg::NUM_TASKS_DEF,
   parameter int COUNT_BITS = csq_pkg::COUNT_BITS_DEF,
   parameter int PRI_BITS   = csq_pkg::PRI_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // sem_id[7:0], task_id[12:8], task_priority[20:13], fifo_order[21],
   // init_count[37:22], max_count[53:38], zero fill[55:54]
   input  logic [55:0] req_tdata,
   // command[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // sem_id_out[4:0], woken_valid[5], woken_task[10:6], woken_by_delete[11],
   // current_count[27:12], first_waiter[32:28], zero fill[39:33]
   output logic [39:0] rsp_tdata,
   // status[2:0]
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast
);
   import csq_pkg::*;

   localparam int SW  = $clog2(NUM_SEMS + 1);
   localparam int TW  = $clog2(NUM_TASKS + 1);
   localparam int SIW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int TIW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

   // Request register.
   fsm_type                 state_ff, state_in;
   cmd_type                 cmd_ff;
   logic [7:0]              sem_ff;
   logic [TASK_FIELD_W-1:0] task_ff;
   logic [PRI_BITS-1:0]     pri_ff;
   logic                    fifo_ff;
   logic [COUNT_BITS-1:0]   ic_ff;
   logic [COUNT_BITS-1:0]   mc_ff;
   logic [15:0]             pri_wide;
   logic [31:0]             ic_wide, mc_wide;

   // Semaphore table.
   logic                  active_ff [NUM_SEMS];
   logic                  mode_ff   [NUM_SEMS];
   logic [COUNT_BITS-1:0] count_ff  [NUM_SEMS];
   logic [COUNT_BITS-1:0] limit_ff  [NUM_SEMS];

   // Task cells.
   logic [SW-1:0]       cell_sem [NUM_TASKS];
   logic [TW-1:0]       cell_pos [NUM_TASKS];
   logic [PRI_BITS-1:0] cell_pri [NUM_TASKS];
   logic [NUM_TASKS-1:0] member, head_hit, ranked_ahead;
   cell_op_type          op;
   logic [TASK_FIELD_W-1:0] op_task;
   logic [TW-1:0]        op_pos;

   // Execution.
   logic                  free_found;
   logic [SIW-1:0]        free_idx;
   logic [7:0]            eff_sem;
   logic                  sem_ok;
   logic [SIW-1:0]        sidx;
   logic [SW-1:0]         sem_key;
   logic                  task_ok;
   logic [TIW-1:0]        tidx;
   logic [TW-1:0]         n_members, n_ahead;
   logic [TASK_FIELD_W-1:0] head_task;
   logic [COUNT_BITS:0]   count_inc;
   logic                  fire;
   logic                  tbl_create, tbl_clear, cnt_we;
   logic [COUNT_BITS-1:0] cnt_val;
   logic [31:0]           cnt_wide;

   // Output register.
   logic        rsp_valid_ff;
   status_type  status_ff, status_in;
   logic [4:0]  sid_ff, sid_in;
   logic        wv_ff, wv_in;
   logic [4:0]  wt_ff, wt_in;
   logic        wd_ff, wd_in;
   logic [15:0] cc_ff, cc_in;
   logic [4:0]  fw_ff, fw_in;
   logic        last_ff, last_in;

   assign req_tready = (state_ff == FSM_IDLE);
   assign pri_wide   = {8'd0, req_tdata[20:13]};
   assign ic_wide    = {16'd0, req_tdata[37:22]};
   assign mc_wide    = {16'd0, req_tdata[53:38]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (req_tvalid && req_tready) begin
         cmd_ff  <= cmd_type'(req_tuser);
         sem_ff  <= req_tdata[7:0];
         task_ff <= req_tdata[12:8];
         pri_ff  <= pri_wide[PRI_BITS-1:0];
         fifo_ff <= req_tdata[21];
         ic_ff   <= ic_wide[COUNT_BITS-1:0];
         mc_ff   <= mc_wide[COUNT_BITS-1:0];
      end
   end

   // Lowest inactive semaphore for create_any.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_SEMS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SIW'(i);
         end
      end
   end

   assign eff_sem = (cmd_ff == CMD_CREATE_ANY) ? 8'(32'(free_idx) + 1) : sem_ff;
   assign sem_ok  = (eff_sem >= 8'd1) && (32'(eff_sem) <= NUM_SEMS);
   assign sidx    = SIW'(32'(eff_sem) - 1);
   assign sem_key = SW'(eff_sem);
   assign task_ok = (task_ff >= TASK_FIELD_W'(1)) && (32'(task_ff) <= NUM_TASKS);
   assign tidx    = TIW'(32'(task_ff) - 1);

   always_comb begin
      head_task = '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
         member[i]       = sem_ok && (cell_sem[i] == sem_key);
         head_hit[i]     = member[i] && (cell_pos[i] == '0);
         ranked_ahead[i] = member[i] && (cell_pri[i] <= pri_ff);
         if (head_hit[i]) begin
            head_task = TASK_FIELD_W'(i + 1);
         end
      end
   end

   assign n_members = TW'($countones(member));
   assign n_ahead   = TW'($countones(ranked_ahead));
   assign count_inc = {1'b0, count_ff[sidx]} + (COUNT_BITS + 1)'(1);
   assign cnt_wide  = 32'(count_ff[sidx]);

   generate
      for (genvar g = 0; g < NUM_TASKS; g++) begin : g_cell
         csq_cell #(
            .IDX      (g),
            .SW       (SW),
            .TW       (TW),
            .PRI_BITS (PRI_BITS)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .op      (op),
            .op_task (op_task),
            .op_sem  (sem_key),
            .op_pos  (op_pos),
            .op_pri  (pri_ff),
            .sem     (cell_sem[g]),
            .pos     (cell_pos[g]),
            .pri     (cell_pri[g])
         );
      end
   endgenerate

   assign fire = (state_ff == FSM_EXEC) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in   = state_ff;
      op         = OP_NONE;
      op_task    = '0;
      op_pos     = '0;
      tbl_create = 1'b0;
      tbl_clear  = 1'b0;
      cnt_we     = 1'b0;
      cnt_val    = count_ff[sidx];
      status_in  = ST_OK;
      sid_in     = eff_sem[4:0];
      wv_in      = 1'b0;
      wt_in      = '0;
      wd_in      = 1'b0;
      cc_in      = '0;
      fw_in      = '0;
      last_in    = 1'b1;
      if (state_ff == FSM_IDLE) begin
         if (req_tvalid) begin
            state_in = FSM_EXEC;
         end
      end else if (fire) begin
         state_in = FSM_IDLE;
         if (cmd_ff == CMD_CREATE_ANY && !free_found) begin
            status_in = ST_NO_FREE_ID;
            sid_in    = '0;
         end else if (!sem_ok) begin
            status_in = ST_BAD_ID;
         end else if (cmd_ff == CMD_CREATE || cmd_ff == CMD_CREATE_ANY) begin
            if (active_ff[sidx]) begin
               status_in = ST_EXISTS;
            end else begin
               tbl_create = 1'b1;
            end
         end else if (!active_ff[sidx]) begin
            status_in = ST_NOT_EXISTS;
         end else begin
            case (cmd_ff)
               CMD_DELETE: begin
                  if (n_members == '0) begin
                     tbl_clear = 1'b1;
                  end else begin
                     // Release the head; the rest move up one place.
                     op      = OP_REMOVE;
                     op_task = head_task;
                     wv_in   = 1'b1;
                     wt_in   = head_task;
                     wd_in   = 1'b1;
                     if (n_members == TW'(1)) begin
                        tbl_clear = 1'b1;
                     end else begin
                        last_in  = 1'b0;
                        state_in = FSM_EXEC;
                     end
                  end
               end
               CMD_SIGNAL: begin
                  if (n_members != '0) begin
                     op      = OP_REMOVE;
                     op_task = head_task;
                     wv_in   = 1'b1;
                     wt_in   = head_task;
                  end else if (count_inc > {1'b0, limit_ff[sidx]}) begin
                     status_in = ST_OVERFLOW;
                  end else begin
                     cnt_we  = 1'b1;
                     cnt_val = count_inc[COUNT_BITS-1:0];
                  end
               end
               CMD_POLL, CMD_WAIT: begin
                  if (count_ff[sidx] != '0) begin
                     cnt_we  = 1'b1;
                     cnt_val = count_ff[sidx] - COUNT_BITS'(1);
                  end else if (cmd_ff == CMD_POLL) begin
                     status_in = ST_WOULD_BLOCK;
                  end else if (!task_ok) begin
                     status_in = ST_BAD_ID;
                  end else if (cell_sem[tidx] != '0) begin
                     status_in = ST_EXISTS;
                  end else begin
                     op        = OP_INSERT;
                     op_task   = task_ff;
                     op_pos    = mode_ff[sidx] ? n_members : n_ahead;
                     status_in = ST_QUEUED;
                  end
               end
               CMD_REFER: begin
                  cc_in = cnt_wide[15:0];
                  fw_in = head_task;
               end
               default: begin
                  if (!task_ok || cell_sem[tidx] != sem_key) begin
                     status_in = ST_NOT_EXISTS;
                  end else begin
                     op      = OP_REMOVE;
                     op_task = task_ff;
                     op_pos  = cell_pos[tidx];
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_SEMS; i++) begin
         if (reset) begin
            active_ff[i] <= 1'b0;
         end else if (SIW'(i) == sidx && tbl_create) begin
            active_ff[i] <= 1'b1;
         end else if (SIW'(i) == sidx && tbl_clear) begin
            active_ff[i] <= 1'b0;
         end
      end
      if (tbl_create) begin
         mode_ff[sidx]  <= fifo_ff;
         count_ff[sidx] <= ic_ff;
         limit_ff[sidx] <= mc_ff;
      end else if (cnt_we) begin
         count_ff[sidx] <= cnt_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (fire) begin
         status_ff <= status_in;
         sid_ff    <= sid_in;
         wv_ff     <= wv_in;
         wt_ff     <= wt_in;
         wd_ff     <= wd_in;
         cc_ff     <= cc_in;
         fw_ff     <= fw_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {7'd0, fw_ff, cc_ff, wd_ff, wt_ff, wv_ff, sid_ff};

`ifndef SYNTHESIS
   // Positions within one queue are distinct, so at most one head exists.
   a_single_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_EXEC) |-> $onehot0(head_hit))
      else $error("more than one head waiter for a semaphore");

   // A release always names a real task.
   a_woken_named: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && wv_ff) |-> (wt_ff != '0))
      else $error("release without a task number");

   // A delete that is not finished keeps the unit busy.
   a_delete_continues: assert property (@(posedge clock) disable iff (reset)
      (fire && !last_in) |=> (state_ff == FSM_EXEC))
      else $error("delete stopped before its last waiter");
`endif

endmodule

FILE: tb/sv/counting_semaphore_wait_queue_unit_tb.sv
// Self-checking testbench for the counting semaphore wait queue unit.
`timescale 1ns / 100ps

module counting_semaphore_wait_queue_unit_tb;
   import csq_pkg::*;

   // One expected response, with the same fields the unit reports.
   typedef struct {
      status_type  status;
      logic [4:0]  sem_id;
      logic        woken_valid;
      logic [4:0]  woken_task;
      logic        woken_by_delete;
      logic [15:0] count;
      logic [4:0]  first_waiter;
      logic        last;
   } sem_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // sem_id[7:0], task_id[12:8], task_priority[20:13], fifo_order[21],
   // init_count[37:22], max_count[53:38], zero fill[55:54]
   logic [55:0] req_tdata;
   // command[2:0]
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // sem_id_out[4:0], woken_valid[5], woken_task[10:6], woken_by_delete[11],
   // current_count[27:12], first_waiter[32:28], zero fill[39:33]
   logic [39:0] rsp_tdata;
   // status[2:0]
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   // Shadow copy of the semaphore table and the task cells. Index 0 is
   // unused so that ids can be used directly.
   bit          sem_live [0:16];
   bit          sem_fifo [0:16];
   logic [15:0] sem_cnt  [0:16];
   logic [15:0] sem_max  [0:16];
   logic [4:0]  q_head   [0:16];
   logic [4:0]  q_next   [0:16];
   logic [7:0]  task_pri [0:16];
   logic [4:0]  task_sem [0:16];

   sem_rsp_type pending_rsps[$];
   int errors;
   int requests_sent;
   int rsps_checked;
   int wakeups_seen;
   int hold_cycles;

   counting_semaphore_wait_queue_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Queues one expected response at the back of the store.
   function automatic void push_rsp(status_type st, logic [4:0] sid, logic wv,
                                    logic [4:0] wt, logic wd, logic [15:0] cnt,
                                    logic [4:0] fw, logic lst);
      sem_rsp_type r;
      r.status = st; r.sem_id = sid; r.woken_valid = wv; r.woken_task = wt;
      r.woken_by_delete = wd; r.count = cnt; r.first_waiter = fw; r.last = lst;
      pending_rsps.push_back(r);
   endfunction

   // Works out every response that one accepted request causes, and updates
   // the shadow table in the same way the unit should.
   function automatic void predict_semaphore_op(cmd_type cmd, logic [7:0] sid8,
                                                logic [4:0] tid, logic [7:0] pri,
                                                logic fifo, logic [15:0] ic,
                                                logic [15:0] mc);
      int s, i, guard, n;
      logic [4:0] prev, cur, nx;
      s = sid8;
      if (cmd == CMD_CREATE_ANY) begin
         s = 0;
         for (i = 16; i >= 1; i--)
            if (!sem_live[i]) s = i;
         if (s == 0) begin
            push_rsp(ST_NO_FREE_ID, 5'd0, 0, 0, 0, 0, 0, 1);
            return;
         end
         cmd = CMD_CREATE;
      end
      if (s < 1 || s > 16) begin
         push_rsp(ST_BAD_ID, sid8[4:0], 0, 0, 0, 0, 0, 1);
         return;
      end
      if (cmd == CMD_CREATE) begin
         if (sem_live[s]) begin
            push_rsp(ST_EXISTS, s[4:0], 0, 0, 0, 0, 0, 1);
         end else begin
            sem_live[s] = 1; sem_fifo[s] = fifo; sem_cnt[s] = ic;
            sem_max[s] = mc; q_head[s] = 0;
            push_rsp(ST_OK, s[4:0], 0, 0, 0, 0, 0, 1);
         end
         return;
      end
      if (!sem_live[s]) begin
         push_rsp(ST_NOT_EXISTS, s[4:0], 0, 0, 0, 0, 0, 1);
         return;
      end
      case (cmd)
         CMD_DELETE: begin
            n = 0;
            cur = q_head[s];
            while (cur != 0 && n < 16) begin
               nx = q_next[cur];
               q_next[cur] = 0;
               task_sem[cur] = 0;
               n++;
               // The final release carries the end-of-run mark.
               push_rsp(ST_OK, s[4:0], 1, cur, 1, 0, 0, nx == 0);
               cur = nx;
            end
            q_head[s] = 0;
            sem_live[s] = 0;
            if (n == 0) push_rsp(ST_OK, s[4:0], 0, 0, 0, 0, 0, 1);
         end
         CMD_SIGNAL: begin
            cur = q_head[s];
            if (cur != 0) begin
               q_head[s] = q_next[cur];
               q_next[cur] = 0;
               task_sem[cur] = 0;
               push_rsp(ST_OK, s[4:0], 1, cur, 0, 0, 0, 1);
            end else if ({1'b0, sem_cnt[s]} + 17'd1 > {1'b0, sem_max[s]}) begin
               push_rsp(ST_OVERFLOW, s[4:0], 0, 0, 0, 0, 0, 1);
            end else begin
               sem_cnt[s]++;
               push_rsp(ST_OK, s[4:0], 0, 0, 0, 0, 0, 1);
            end
         end
         CMD_POLL, CMD_WAIT: begin
            if (sem_cnt[s] != 0) begin
               sem_cnt[s]--;
               push_rsp(ST_OK, s[4:0], 0, 0, 0, 0, 0, 1);
            end else if (cmd == CMD_POLL) begin
               push_rsp(ST_WOULD_BLOCK, s[4:0], 0, 0, 0, 0, 0, 1);
            end else if (tid < 1 || tid > 16) begin
               push_rsp(ST_BAD_ID, s[4:0], 0, 0, 0, 0, 0, 1);
            end else if (task_sem[tid] != 0) begin
               push_rsp(ST_EXISTS, s[4:0], 0, 0, 0, 0, 0, 1);
            end else begin
               // Walk to the insertion point: the end for arrival order, or
               // past every waiter of equal or better priority.
               prev = 0; cur = q_head[s]; guard = 0;
               while (cur != 0 && guard < 16) begin
                  if (!sem_fifo[s] && task_pri[cur] > pri) break;
                  prev = cur; cur = q_next[cur]; guard++;
               end
               q_next[tid] = cur; task_pri[tid] = pri; task_sem[tid] = s;
               if (prev == 0) q_head[s] = tid;
               else q_next[prev] = tid;
               push_rsp(ST_QUEUED, s[4:0], 0, 0, 0, 0, 0, 1);
            end
         end
         CMD_REFER: begin
            push_rsp(ST_OK, s[4:0], 0, 0, 0, sem_cnt[s], q_head[s], 1);
         end
         default: begin
            if (tid < 1 || tid > 16 || task_sem[tid] != s) begin
               push_rsp(ST_NOT_EXISTS, s[4:0], 0, 0, 0, 0, 0, 1);
            end else begin
               prev = 0; cur = q_head[s]; guard = 0;
               while (cur != 0 && guard < 16) begin
                  if (cur == tid) begin
                     if (prev == 0) q_head[s] = q_next[cur];
                     else q_next[prev] = q_next[cur];
                     break;
                  end
                  prev = cur; cur = q_next[cur]; guard++;
               end
               q_next[tid] = 0;
               task_sem[tid] = 0;
               push_rsp(ST_OK, s[4:0], 0, 0, 0, 0, 0, 1);
            end
         end
      endcase
   endfunction

   // Offers one request from the falling edge and holds it until the rising
   // edge at which the unit takes it. The valid line is left high, so that a
   // request that follows straight after keeps the channel busy.
   task automatic issue_call(cmd_type cmd, logic [7:0] sid, logic [4:0] tid,
                             logic [7:0] pri, logic fifo, logic [15:0] ic,
                             logic [15:0] mc);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = {2'b00, mc, ic, fifo, pri, tid, sid};
      do @(posedge clock); while (!req_tready);
      predict_semaphore_op(cmd, sid, tid, pri, fifo, ic, mc);
      requests_sent++;
   endtask

   task automatic idle_sender(int cycles);
      @(negedge clock);
      req_tvalid = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic wait_for_drain();
      while (pending_rsps.size() != 0) @(posedge clock);
   endtask

   // Bad ids, inactive semaphores and the create error cases.
   task automatic test_id_checks();
      issue_call(CMD_REFER, 8'd0, 5'd1, 8'd0, 1'b0, 16'd0, 16'd0);
      issue_call(CMD_SIGNAL, 8'd17, 5'd1, 8'd0, 1'b0, 16'd0, 16'd0);
      issue_call(CMD_CREATE, 8'd255, 5'd1, 8'd0, 1'b0, 16'd0, 16'd0);
      issue_call(CMD_POLL, 8'd5, 5'd1, 8'd0, 1'b0, 16'd0, 16'd0);
      issue_call(CMD_CREATE, 8'd5, 5'd31, 8'd255, 1'b1, 16'hFFFF, 16'hFFFF);
      issue_call(CMD_CREATE, 8'd5, 5'd0, 8'd0, 1'b0, 16'd0, 16'd0);
      // Signal at the limit overflows; poll takes a unit of count, then refer reads it.
      issue_call(CMD_SIGNAL, 8'd5, 5'd0, 8'd0, 1'b0, 16'd0, 16'd0);
      issue_call(CMD_POLL, 8'd5, 5'd0, 8'd0, 1'b0, 16'd0, 16'd0);
      issue_call(CMD_REFER, 8'd5, 5'd0, 8'd0, 1'b0, 16'd0, 16'd0);
      // A start above its limit is kept, and signal then overflows.
      issue_call(CMD_CREATE, 8'd16, 5'd0, 8'd0, 1'b1, 16'd9, 16'd3);
      issue_call(CMD_SIGNAL, 8'd16, 5'd0, 8'd0, 1'b0, 16'd0, 16'd0);
      issue_call(CMD_DELETE, 8'd16, 5'd0, 8'd0, 1'b0, 16'd0, 16'd0);
   endtask

   // Priority ordering with ties, a bad and a repeated waiter, a drop, a
   // signal that wakes the head and a delete that wakes the rest.
   task automatic test_wait_queue();
      issue_call(CMD_CREATE, 8'd1, 5'd0, 8'd0, 1'b0, 16'd0, 16'd1);
      issue_call(CMD_POLL, 8'd1, 5'd0, 8'd0, 1'b0, 16'd0, 16'd0);
      issue_call(CMD_WAIT, 8'd1, 5'd3, 8'd20, 1'b0, 16'd0, 16'd0);
      issue_call(CMD_WAIT, 8'd1, 5'd7, 8'd20, 1'b0, 16'd0, 16'd0);
      issue_call(CMD_WAIT, 8'd1, 5'd16, 8'd0, 1'b0, 16'd0, 16'd0);
      issue_call(CMD_WAIT, 8'd1, 5'd0, 8'd1, 1'b0, 16'd0, 16'd0);
      issue_call(CMD_WAIT, 8'd1, 5'd7, 8'd1, 1'b0, 16'd0, 16'd0);
      issue_call(CMD_REFER, 8'd1, 5'd0, 8'd0, 1'b0, 16'd0, 16'd0);
      issue_call(CMD_DROP, 8'd1, 5'd3, 8'd0, 1'b0, 16'd0, 16'd0);
      issue_call(CMD_DROP, 8'd1, 5'd3, 8'd0, 1'b0, 16'd0, 16'd0);
      issue_call(CMD_SIGNAL, 8'd1, 5'd0, 8'd0, 1'b0, 16'd0, 16'd0);
      issue_call(CMD_DELETE, 8'd1, 5'd0, 8'd0, 1'b0, 16'd0, 16'd0);
   endtask

   // Every free id taken by create_any, the rest find none free, then all go.
   task automatic test_table_full();
      int i;
      for (i = 0; i < 17; i++)
         issue_call(CMD_CREATE_ANY, 8'($urandom), 5'd0, 8'd0, 1'($urandom),
                    16'd0, 16'd2);
      for (i = 1; i <= 16; i++)
         issue_call(CMD_DELETE, 8'(i), 5'd0, 8'd0, 1'b0, 16'd0, 16'd0);
   endtask

   // The receiver holds off for a long stretch while requests keep coming,
   // so the unit fills and stalls its input; then the sender waits for all.
   task automatic test_backpressure();
      int i;
      hold_cycles = 150;
      for (i = 0; i < 10; i++)
         issue_call(CMD_CREATE_ANY, 8'd0, 5'd0, 8'd0, 1'b1, 16'd0, 16'd0);
      idle_sender(0);
      wait_for_drain();
      for (i = 1; i <= 10; i++)
         issue_call(CMD_DELETE, 8'(i), 5'd0, 8'd0, 1'b0, 16'd0, 16'd0);
   endtask

   // Random calls, mostly well formed on a few semaphores so that queues
   // grow, with a share of out-of-range ids and full-width field values.
   task automatic test_random_calls(int count);
      int i, burst, roll;
      cmd_type cmd;
      logic [7:0] sid, pri;
      logic [4:0] tid;
      logic [15:0] ic, mc;
      i = 0;
      while (i < count) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && i < count) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) cmd = CMD_CREATE;
            else if (roll < 16) cmd = CMD_CREATE_ANY;
            else if (roll < 24) cmd = CMD_DELETE;
            else if (roll < 40) cmd = CMD_SIGNAL;
            else if (roll < 46) cmd = CMD_POLL;
            else if (roll < 80) cmd = CMD_WAIT;
            else if (roll < 90) cmd = CMD_REFER;
            else cmd = CMD_DROP;
            sid = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 4));
            tid = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
            pri = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
            ic  = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1));
            mc  = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
            issue_call(cmd, sid, tid, pri, 1'($urandom), ic, mc);
            burst--;
            i++;
         end
         if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 20));
      end
   endtask

   // Receiver: a long hold-off when asked, otherwise stretches of steady
   // acceptance alternating with random stalls.
   initial begin : rsp_ready_gen
      int phase;
      phase = 0;
      forever begin
         @(negedge clock);
         phase++;
         if (hold_cycles > 0) begin
            rsp_tready = 1'b0;
            hold_cycles--;
         end else if ((phase / 48) % 2 == 0) begin
            rsp_tready = 1'b1;
         end else begin
            rsp_tready = ($urandom_range(0, 3) != 0);
         end
      end
   end

   // Compares every accepted response with the oldest expectation.
   initial begin : rsp_checker
      sem_rsp_type e;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_rsps.size() == 0) begin
               $display("%0t: unexpected response tuser=%0d tdata=%h last=%b",
                        $time, rsp_tuser, rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               e = pending_rsps.pop_front();
               rsps_checked++;
               if (rsp_tdata[5]) wakeups_seen++;
               if (rsp_tuser !== e.status || rsp_tdata[4:0] !== e.sem_id ||
                   rsp_tdata[5] !== e.woken_valid || rsp_tdata[10:6] !== e.woken_task ||
                   rsp_tdata[11] !== e.woken_by_delete ||
                   rsp_tdata[27:12] !== e.count ||
                   rsp_tdata[32:28] !== e.first_waiter || rsp_tdata[39:33] !== 7'd0 ||
                   rsp_tlast !== e.last) begin
                  $display("%0t: expected st=%0d id=%0d wv=%b wt=%0d wd=%b %s",
                           $time, e.status, e.sem_id, e.woken_valid, e.woken_task,
                           e.woken_by_delete,
                           $sformatf("cnt=%0d fw=%0d last=%b",
                                     e.count, e.first_waiter, e.last));
                  $display("%0t: actual   st=%0d id=%0d wv=%b wt=%0d wd=%b %s",
                           $time, rsp_tuser, rsp_tdata[4:0], rsp_tdata[5],
                           rsp_tdata[10:6], rsp_tdata[11],
                           $sformatf("cnt=%0d fw=%0d last=%b",
                                     rsp_tdata[27:12], rsp_tdata[32:28], rsp_tlast));
                  errors++;
               end
            end
         end
      end
   end

   initial begin : watchdog
      #3000000;
      $display("[counting_semaphore_wait_queue_unit] ERROR");
      $finish;
   end

   initial begin : main_seq
      int k;
      errors = 0; requests_sent = 0; rsps_checked = 0; wakeups_seen = 0;
      hold_cycles = 0;
      // The shadow store starts cleared, as the unit's does.
      for (k = 0; k <= 16; k++) begin
         sem_live[k] = 0; sem_fifo[k] = 0; sem_cnt[k] = '0; sem_max[k] = '0;
         q_head[k] = '0; q_next[k] = '0; task_pri[k] = '0; task_sem[k] = '0;
      end
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = '0;
      rsp_tready = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_id_checks();
      test_wait_queue();
      test_table_full();
      test_backpressure();
      test_random_calls(55);

      idle_sender(0);
      wait_for_drain();
      repeat (40) @(posedge clock);

      $display("Covered %0d requests: id checks, ordered queues, full table,", requests_sent);
      $display("back-pressure and random calls; checked %0d responses, %0d releases, %0d errors.",
               rsps_checked, wakeups_seen, errors);
      if (errors == 0 && pending_rsps.size() == 0) begin
         $display("[counting_semaphore_wait_queue_unit] OK");
      end else begin
         $display("[counting_semaphore_wait_queue_unit] ERROR");
      end
      $finish;
   end

endmodule
